@@ rtl/mctt_pkg.sv @@
package mctt_pkg;

    // Default number of timer entries held in the state memories.
    localparam int NUM_TIMERS_DEFAULT = 16;

    // Timers reachable through the 4-bit timer_id field.
    localparam int ADDRESSABLE = 16;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SET    = 2'd1,
        OP_CANCEL = 2'd2
    } op_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

endpackage

@@ rtl/multi_channel_tick_timers.sv @@
// Bank of one-shot and periodic tick timers.
//
// Input channel (in_valid/in_ready): op selects tick, set or cancel. A valid
// set arms timer_id with timeout and period (period zero is one-shot); an
// in-range cancel disarms it. Each set or cancel yields one status transfer
// on the output channel (kind 0) with last high.
// A tick counts every armed timer down and yields one expiry transfer
// (kind 1) per timer that reaches zero, in ascending timer index; the final
// expiry of a tick carries last. A tick with no expiry yields nothing.
//
// Output channel (out_valid/out_ready) is a single output register. A set or
// cancel does not leave idle. A tick walks the timer memories once, one
// entry per cycle unless the scan stalls, through a read / modify /
// write-back pipeline: in_ready stays low from the tick transfer until
// the scan ends, also while the receiver stalls. The scan keeps one
// expiry in hand so it can flag last; while the receiver stalls and a
// second expiry is found, the scan holds in place.
//
// Reset clears all armed flags and the output register; count and period
// memories are only used for armed timers, so they need no clearing.
module multi_channel_tick_timers #(
    parameter int NUM_TIMERS = mctt_pkg::NUM_TIMERS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [3:0]  timer_id,
    input  logic [31:0] timeout,
    input  logic [31:0] period,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [3:0]  fired_id,
    output logic        status,
    output logic        last
);

    // Only the first 16 entries can ever be addressed and armed.
    localparam int SLOTS = (NUM_TIMERS < mctt_pkg::ADDRESSABLE) ?
                           NUM_TIMERS : mctt_pkg::ADDRESSABLE;
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Timer state memories: one read and one write port each.
    logic [31:0]            rem_mem [NUM_TIMERS];
    logic [31:0]            per_mem [NUM_TIMERS];

    state_t                 state_reg, state_next;
    logic [NUM_TIMERS-1:0]  armed_reg, armed_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   b_vld_reg, b_vld_next;
    logic [IDX_W-1:0]       b_idx_reg, b_idx_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [3:0]             pend_id_reg, pend_id_next;
    logic [31:0]            rem_rd_reg;
    logic [31:0]            per_rd_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   kind_reg, kind_next;
    logic [3:0]             fired_id_reg, fired_id_next;
    logic                   status_reg, status_next;
    logic                   last_reg, last_next;

    // Memory port controls
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rem_we;
    logic                   per_we;
    logic [IDX_W-1:0]       wr_addr;
    logic [31:0]            rem_wdata;
    logic [31:0]            per_wdata;

    logic                   out_free;
    logic                   in_fire;
    logic                   in_range;
    logic                   set_bad;
    logic [IDX_W-1:0]       in_idx;
    logic                   b_armed;
    logic [31:0]            rem_dec;
    logic                   b_hit;
    logic                   b_reload;
    logic                   rd_more;
    logic                   stall;
    logic                   scan_end;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign in_range = ({1'b0, timer_id} < 5'(SLOTS));
    assign set_bad  = !in_range || (timeout == '0) ||
                      (period == mctt_pkg::ALL_ONES);
    assign in_idx   = IDX_W'(timer_id);

    // Evaluate stage: entry b_idx_reg with its memory words just read.
    assign b_armed  = b_vld_reg && armed_reg[b_idx_reg];
    assign rem_dec  = rem_rd_reg - 32'd1;
    assign b_hit    = b_armed && (rem_dec == '0);
    assign b_reload = (per_rd_reg != '0);
    assign rd_more  = (rd_idx_reg < CNT_W'(SLOTS));
    // A second expiry cannot be taken while the held one cannot leave.
    assign stall    = b_hit && pend_vld_reg && !out_free;
    assign scan_end = !b_vld_reg && !rd_more;

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        rd_idx_next    = rd_idx_reg;
        b_vld_next     = b_vld_reg;
        b_idx_next     = b_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_id_next   = pend_id_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        fired_id_next  = fired_id_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        rd_addr        = IDX_W'(rd_idx_reg);
        rem_we         = 1'b0;
        per_we         = 1'b0;
        wr_addr        = in_idx;
        rem_wdata      = timeout;
        per_wdata      = period;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (mctt_pkg::op_t'(op))
                        mctt_pkg::OP_TICK:
                        begin
                            state_next    = ST_SCAN;
                            rd_idx_next   = '0;
                            b_vld_next    = 1'b0;
                            pend_vld_next = 1'b0;
                        end
                        mctt_pkg::OP_SET:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = mctt_pkg::KIND_STATUS;
                            fired_id_next  = timer_id;
                            last_next      = 1'b1;
                            status_next    = set_bad ? mctt_pkg::STATUS_BAD
                                                     : mctt_pkg::STATUS_OK;
                            if (!set_bad)
                            begin
                                armed_next[in_idx] = 1'b1;
                                rem_we             = 1'b1;
                                per_we             = 1'b1;
                            end
                        end
                        mctt_pkg::OP_CANCEL:
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = mctt_pkg::KIND_STATUS;
                            fired_id_next  = timer_id;
                            last_next      = 1'b1;
                            status_next    = in_range ? mctt_pkg::STATUS_OK
                                                      : mctt_pkg::STATUS_BAD;
                            if (in_range)
                            begin
                                armed_next[in_idx] = 1'b0;
                                rem_we             = 1'b1;
                                rem_wdata          = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    // Flush the held expiry with last set, then go idle.
                    if (!pend_vld_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = mctt_pkg::KIND_FIRE;
                        fired_id_next  = pend_id_reg;
                        status_next    = mctt_pkg::STATUS_OK;
                        last_next      = 1'b1;
                        pend_vld_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (!stall)
                begin
                    rd_en      = rd_more;
                    b_vld_next = rd_more;
                    b_idx_next = IDX_W'(rd_idx_reg);
                    if (rd_more)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    if (b_armed)
                    begin
                        rem_we    = 1'b1;
                        wr_addr   = b_idx_reg;
                        rem_wdata = (b_hit && b_reload) ? per_rd_reg : rem_dec;
                        if (b_hit && !b_reload)
                        begin
                            armed_next[b_idx_reg] = 1'b0;
                        end
                    end
                    if (b_hit)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = mctt_pkg::KIND_FIRE;
                            fired_id_next  = pend_id_reg;
                            status_next    = mctt_pkg::STATUS_OK;
                            last_next      = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_id_next  = 4'(b_idx_reg);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State memories; read data holds while the scan is stalled.
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[wr_addr] <= rem_wdata;
        end
        if (per_we)
        begin
            per_mem[wr_addr] <= per_wdata;
        end
        if (rd_en)
        begin
            rem_rd_reg <= rem_mem[rd_addr];
            per_rd_reg <= per_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            armed_reg     <= '0;
            rd_idx_reg    <= '0;
            b_vld_reg     <= 1'b0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            rd_idx_reg    <= rd_idx_next;
            b_vld_reg     <= b_vld_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_idx_reg    <= b_idx_next;
        pend_id_reg  <= pend_id_next;
        kind_reg     <= kind_next;
        fired_id_reg <= fired_id_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign fired_id  = fired_id_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    // A stalled scan keeps its evaluated entry.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stall) |=> (b_vld_reg && $stable(b_idx_reg)))
        else $error("scan stall lost the evaluated entry");

    // No held expiry survives into idle.
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !pend_vld_reg)
        else $error("input taken with an expiry still held");

    // Expiries always report accepted status.
    a_fire_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == mctt_pkg::KIND_FIRE)
            |-> (status_reg == mctt_pkg::STATUS_OK))
        else $error("expiry with bad status");

    // Set and cancel results are always the last of their item.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == mctt_pkg::KIND_STATUS) |-> last_reg)
        else $error("status result without last");

    // Read counter stays within the scanned range.
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= CNT_W'(SLOTS))
        else $error("scan read index out of range");

endmodule
